// ===== hw/rtl/lab_pkg.sv =====
// ----------------------------------------------------------------------------
// lab_pkg: shared definitions for the light attenuation block
// Widths, mode and register codes, fixed-point constants and the
// structures that travel between the pipeline sections.
// ----------------------------------------------------------------------------
package lab_pkg;

  // field widths
  localparam int unsigned DistW    = 24;  // distance, unsigned Q12.12
  localparam int unsigned SlopeW   = 24;  // linear slope, unsigned Q8.16
  localparam int unsigned CoeffW   = 32;  // polynomial coefficients, Q16.16
  localparam int unsigned BrightW  = 32;  // result, signed Q16.16
  localparam int unsigned ModeW    = 3;
  localparam int unsigned DataW    = 32;  // config data bus
  localparam int unsigned AddrW    = 5;   // six word registers
  localparam int unsigned RegIdxW  = 3;

  // internal widths
  localparam int unsigned DistFracW = 12;           // fraction bits of distance
  localparam int unsigned LinFracW  = 28;           // slope times distance, Q.28
  localparam int unsigned MulAW     = CoeffW + 1;   // coefficient or zero-extended slope
  localparam int unsigned MulBW     = DistW + 1;    // distance as a signed operand
  localparam int unsigned Prod1W    = MulAW + MulBW;
  localparam int unsigned LTermW    = Prod1W - DistFracW;
  localparam int unsigned SqW       = 2 * DistW;    // squared distance
  localparam int unsigned SqHalfW   = DistW;        // split of the square for partials
  localparam int unsigned QProdW    = CoeffW + SqHalfW + 1;
  localparam int unsigned QLoHiW    = QProdW - SqHalfW;
  localparam int unsigned SumW      = 60;           // exact polynomial sum
  localparam int unsigned QuotW     = 31;           // divider quotient bits
  localparam int unsigned InvExp    = 28;           // inverse numerator 2^28
  localparam int unsigned InvSqExp  = 40;           // inverse square numerator 2^40

  // attenuation modes
  localparam logic [ModeW-1:0] ModeNone    = 3'd0;
  localparam logic [ModeW-1:0] ModeLinear  = 3'd1;
  localparam logic [ModeW-1:0] ModeInverse = 3'd2;
  localparam logic [ModeW-1:0] ModeInvSq   = 3'd3;
  localparam logic [ModeW-1:0] ModePoly    = 3'd4;

  // register indexes
  localparam logic [RegIdxW-1:0] RegMode    = 3'd0;
  localparam logic [RegIdxW-1:0] RegSlope   = 3'd1;
  localparam logic [RegIdxW-1:0] RegConst   = 3'd2;
  localparam logic [RegIdxW-1:0] RegLin     = 3'd3;
  localparam logic [RegIdxW-1:0] RegQuad    = 3'd4;
  localparam logic [RegIdxW-1:0] RegMinDist = 3'd5;

  // fixed-point constants
  localparam logic [BrightW-1:0]  OneQ16  = 32'h0001_0000;
  localparam logic [BrightW-1:0]  MaxS32  = 32'h7FFF_FFFF;
  localparam logic [BrightW-1:0]  MinS32  = 32'h8000_0000;
  localparam logic [LinFracW:0]   LinOne  = (LinFracW + 1)'(1) << LinFracW;
  // low dividend bits of 2^28, the high part is zero
  localparam logic [QuotW-1:0]    InvNumLo  = QuotW'(1) << InvExp;
  // high part of 2^40 above the quotient bits; a square at or below it
  // gives a quotient that does not fit in 31 bits
  localparam logic [SqW-1:0]      InvSqHead = SqW'(1) << (InvSqExp - QuotW);

  typedef struct packed {
    logic [ModeW-1:0]  atten_mode;
    logic [SlopeW-1:0] linear_slope;
    logic [CoeffW-1:0] const_coeff;
    logic [CoeffW-1:0] lin_coeff;
    logic [CoeffW-1:0] quad_coeff;
    logic [DistW-1:0]  min_distance;
  } cfg_t;

  // front section to polynomial section
  typedef struct packed {
    logic [DistW-1:0]   dc;       // distance raised to the minimum
    logic [SqW-1:0]     sq;       // d*d in polynomial mode, else dc*dc
    logic [BrightW-1:0] lin_res;  // finished linear mode result
    logic [LTermW-1:0]  lterm;    // floor(l*d / 2^12)
  } front_t;

  // divider stage contents
  typedef struct packed {
    logic               use_div;
    logic               saturated;
    logic [BrightW-1:0] res;
    logic [SqW-1:0]     rem;
    logic [SqW-1:0]     den;
    logic [QuotW-1:0]   quot;     // dividend bits shift out, quotient bits in
  } div_t;

  typedef struct packed {
    logic [BrightW-1:0] brightness;
    logic               saturated;
  } res_t;

endpackage

// ===== hw/rtl/lab_front.sv =====
// ----------------------------------------------------------------------------
// lab_front: distance clamp, first product and square
// Stage one clamps the distance and forms slope*d or l*d; stage two
// squares the distance and finishes the linear mode result.
// ----------------------------------------------------------------------------
module lab_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  lab_pkg::cfg_t             cfg_i,
  input  logic                      valid_i,
  input  logic [lab_pkg::DistW-1:0] distance_i,
  output logic                      valid_o,
  output lab_pkg::front_t           front_o
);

  logic                               poly;
  logic [lab_pkg::DistW-1:0]          dmin;
  logic [lab_pkg::DistW-1:0]          dc;
  logic signed [lab_pkg::MulAW-1:0]   mul_a;
  logic signed [lab_pkg::MulBW-1:0]   mul_b;
  logic signed [lab_pkg::Prod1W-1:0]  prod1_d, prod1_q;
  logic [lab_pkg::DistW-1:0]          d1_q, dc1_q;
  logic                               v1_q, v2_q;
  logic [lab_pkg::DistW-1:0]          sq_x;
  logic [lab_pkg::LinFracW:0]         lin_diff;
  lab_pkg::front_t                    front_d, front_q;

  assign poly = (cfg_i.atten_mode == lab_pkg::ModePoly);

  // stage one: clamp and shared multiplier
  always_comb begin
    dmin  = (cfg_i.min_distance == '0) ? lab_pkg::DistW'(1) : cfg_i.min_distance;
    dc    = (distance_i < dmin) ? dmin : distance_i;
    mul_a = poly ? $signed({cfg_i.lin_coeff[lab_pkg::CoeffW-1], cfg_i.lin_coeff})
                 : $signed({{(lab_pkg::MulAW - lab_pkg::SlopeW){1'b0}},
                            cfg_i.linear_slope});
    mul_b = $signed({1'b0, distance_i});
    prod1_d = mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1_q    <= distance_i;
      dc1_q   <= dc;
      prod1_q <= prod1_d;
    end
  end

  // stage two: square, linear clamp, floored distance term
  always_comb begin
    sq_x       = poly ? d1_q : dc1_q;
    front_d.dc = dc1_q;
    front_d.sq = sq_x * sq_x;
    lin_diff   = lab_pkg::LinOne - {1'b0, prod1_q[lab_pkg::LinFracW-1:0]};
    if (|prod1_q[lab_pkg::Prod1W-1:lab_pkg::LinFracW]) begin
      front_d.lin_res = '0;
    end else begin
      front_d.lin_res = lab_pkg::BrightW'(lin_diff[lab_pkg::LinFracW:lab_pkg::DistFracW]);
    end
    // arithmetic shift right is a floor
    front_d.lterm = prod1_q[lab_pkg::Prod1W-1:lab_pkg::DistFracW];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      front_q <= front_d;
    end
  end

  assign valid_o = v2_q;
  assign front_o = front_q;

endmodule

// ===== hw/rtl/lab_poly.sv =====
// ----------------------------------------------------------------------------
// lab_poly: polynomial terms, exact sum, saturation and mode select
// Four stages: low partial of q*d^2, high partial, final add, then the
// result choice and the setup of the divider operands.
// ----------------------------------------------------------------------------
module lab_poly (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  lab_pkg::cfg_t   cfg_i,
  input  logic            valid_i,
  input  lab_pkg::front_t front_i,
  output logic            valid_o,
  output lab_pkg::div_t   div_o
);

  localparam logic signed [lab_pkg::SumW-1:0] SumMax =
    lab_pkg::SumW'($signed(lab_pkg::MaxS32));
  localparam logic signed [lab_pkg::SumW-1:0] SumMin =
    lab_pkg::SumW'($signed(lab_pkg::MinS32));

  logic signed [lab_pkg::CoeffW-1:0]  c_s, q_s;
  logic signed [lab_pkg::LTermW-1:0]  lterm_s;
  logic signed [lab_pkg::SqHalfW:0]   dlo, dhi;
  logic signed [lab_pkg::QProdW-1:0]  plo_d, plo_q, phi_d, phi_q;
  logic signed [lab_pkg::QLoHiW-1:0]  plo_hi;
  logic signed [lab_pkg::SumW-1:0]    parta_d, parta_q, part_d, part_q, sum_d, sum_q;
  lab_pkg::front_t                    f3_q, f4_q, f5_q;
  lab_pkg::div_t                      div_d, div_q;
  logic                               v3_q, v4_q, v5_q, v6_q;

  assign c_s = $signed(cfg_i.const_coeff);
  assign q_s = $signed(cfg_i.quad_coeff);

  // stage three: q times the low half of the square, constant plus distance term
  always_comb begin
    lterm_s = $signed(front_i.lterm);
    dlo     = $signed({1'b0, front_i.sq[lab_pkg::SqHalfW-1:0]});
    plo_d   = q_s * dlo;
    parta_d = lab_pkg::SumW'(c_s) + lab_pkg::SumW'(lterm_s);
  end

  // stage four: q times the high half; floor of the low partial joins the sum
  always_comb begin
    dhi    = $signed({1'b0, f3_q.sq[lab_pkg::SqW-1:lab_pkg::SqHalfW]});
    phi_d  = q_s * dhi;
    plo_hi = plo_q[lab_pkg::QProdW-1:lab_pkg::SqHalfW];
    part_d = parta_q + lab_pkg::SumW'(plo_hi);
  end

  // stage five: exact polynomial sum
  assign sum_d = part_q + lab_pkg::SumW'(phi_q);

  // stage six: pick the result or hand the operands to the divider
  always_comb begin
    div_d = '0;
    case (cfg_i.atten_mode)
      lab_pkg::ModeNone: begin
        div_d.res = lab_pkg::OneQ16;
      end
      lab_pkg::ModeLinear: begin
        div_d.res = f5_q.lin_res;
      end
      lab_pkg::ModeInverse: begin
        div_d.use_div = 1'b1;
        div_d.rem     = '0;
        div_d.den     = lab_pkg::SqW'(f5_q.dc);
        div_d.quot    = lab_pkg::InvNumLo;
      end
      lab_pkg::ModeInvSq: begin
        if (f5_q.sq <= lab_pkg::InvSqHead) begin
          div_d.res       = lab_pkg::MaxS32;
          div_d.saturated = 1'b1;
        end else begin
          div_d.use_div = 1'b1;
          div_d.rem     = lab_pkg::InvSqHead;
          div_d.den     = f5_q.sq;
          div_d.quot    = '0;
        end
      end
      lab_pkg::ModePoly: begin
        if (sum_q > SumMax) begin
          div_d.res       = lab_pkg::MaxS32;
          div_d.saturated = 1'b1;
        end else if (sum_q < SumMin) begin
          div_d.res       = lab_pkg::MinS32;
          div_d.saturated = 1'b1;
        end else begin
          div_d.res = sum_q[lab_pkg::BrightW-1:0];
        end
      end
      default: begin
        div_d.res = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= valid_i;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f3_q    <= front_i;
      plo_q   <= plo_d;
      parta_q <= parta_d;
      f4_q    <= f3_q;
      phi_q   <= phi_d;
      part_q  <= part_d;
      f5_q    <= f4_q;
      sum_q   <= sum_d;
      div_q   <= div_d;
    end
  end

  assign valid_o = v6_q;
  assign div_o   = div_q;

endmodule

// ===== hw/rtl/lab_div.sv =====
// ----------------------------------------------------------------------------
// lab_div: pipelined restoring divider
// One quotient bit per stage over 31 stages; items that need no
// division ride along with their finished result.
// ----------------------------------------------------------------------------
module lab_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  lab_pkg::div_t div_i,
  output logic          valid_o,
  output lab_pkg::res_t res_o
);

  lab_pkg::div_t stage_q [lab_pkg::QuotW];
  logic          v_q     [lab_pkg::QuotW];
  lab_pkg::div_t last;

  for (genvar k = 0; k < lab_pkg::QuotW; k++) begin : g_step
    lab_pkg::div_t          src, nxt;
    logic                   src_v;
    logic [lab_pkg::SqW:0]  trial, diff;
    logic                   ge;

    if (k == 0) begin : g_first
      assign src   = div_i;
      assign src_v = valid_i;
    end else begin : g_next
      assign src   = stage_q[k-1];
      assign src_v = v_q[k-1];
    end

    // bring in the next dividend bit, subtract when it fits
    always_comb begin
      trial    = {src.rem, src.quot[lab_pkg::QuotW-1]};
      diff     = trial - {1'b0, src.den};
      ge       = (trial >= {1'b0, src.den});
      nxt      = src;
      nxt.rem  = ge ? diff[lab_pkg::SqW-1:0] : trial[lab_pkg::SqW-1:0];
      nxt.quot = {src.quot[lab_pkg::QuotW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stage_q[k] <= nxt;
      end
    end
  end

  // final result
  assign last             = stage_q[lab_pkg::QuotW-1];
  assign valid_o          = v_q[lab_pkg::QuotW-1];
  assign res_o.brightness = last.use_div ? lab_pkg::BrightW'(last.quot) : last.res;
  assign res_o.saturated  = last.saturated;

  // the partial remainder stays below the divisor through every step
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[lab_pkg::QuotW-1] && last.use_div) |-> (last.rem < last.den))
    else $error("divider remainder not below divisor");

endmodule

// ===== hw/rtl/light_attenuation_brightness.sv =====
// ----------------------------------------------------------------------------
// light_attenuation_brightness: light brightness at a distance
// Configuration registers, the arithmetic pipeline and an output
// register with one skid entry.
//
//   channel  direction  handshake                 payload
//   in       to block   in_valid_i / in_stall_o   distance_i
//   out      from block out_valid_o / out_stall_i brightness_o, saturated_o
//   cfg      to block   psel, penable, pready     paddr, pwdata, prdata
//
// One distance is accepted every cycle while in_stall_o is low; an accepted request
// passes through six arithmetic stages, 31 divider stages and the output reg.
// The pipeline depth is set by the restoring divider, one quotient bit per stage.
// Reset clears the valid bits and loads the register reset values at once.
// When the output stalls, the skid entry takes one result; while it is full
// in_stall_o is high and every pipeline stage holds.
// ----------------------------------------------------------------------------
module light_attenuation_brightness (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lab_pkg::AddrW-1:0]   paddr,
  input  logic [lab_pkg::DataW-1:0]   pwdata,
  output logic [lab_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  // distance requests
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [lab_pkg::DistW-1:0]   distance_i,
  // brightness results
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [lab_pkg::BrightW-1:0] brightness_o,
  output logic                        saturated_o
);

  logic [lab_pkg::RegIdxW-1:0] reg_idx;
  logic                        cfg_wr;
  lab_pkg::cfg_t               cfg_q;

  logic                        en;
  logic                        front_v, poly_v, pipe_v;
  lab_pkg::front_t             front;
  lab_pkg::div_t               div_in;
  lab_pkg::res_t               pipe_res;
  logic                        pipe_move, out_take;
  logic                        out_v_q, skid_v_q;
  lab_pkg::res_t               out_q, skid_q;

  // register access
  assign pready  = 1'b1;
  assign reg_idx = paddr[lab_pkg::AddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.atten_mode   <= lab_pkg::ModeLinear;
      cfg_q.linear_slope <= '0;
      cfg_q.const_coeff  <= '0;
      cfg_q.lin_coeff    <= '0;
      cfg_q.quad_coeff   <= '0;
      cfg_q.min_distance <= lab_pkg::DistW'(1);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        lab_pkg::RegMode:    cfg_q.atten_mode   <= pwdata[lab_pkg::ModeW-1:0];
        lab_pkg::RegSlope:   cfg_q.linear_slope <= pwdata[lab_pkg::SlopeW-1:0];
        lab_pkg::RegConst:   cfg_q.const_coeff  <= pwdata[lab_pkg::CoeffW-1:0];
        lab_pkg::RegLin:     cfg_q.lin_coeff    <= pwdata[lab_pkg::CoeffW-1:0];
        lab_pkg::RegQuad:    cfg_q.quad_coeff   <= pwdata[lab_pkg::CoeffW-1:0];
        lab_pkg::RegMinDist: cfg_q.min_distance <= pwdata[lab_pkg::DistW-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      lab_pkg::RegMode:    prdata = lab_pkg::DataW'(cfg_q.atten_mode);
      lab_pkg::RegSlope:   prdata = lab_pkg::DataW'(cfg_q.linear_slope);
      lab_pkg::RegConst:   prdata = cfg_q.const_coeff;
      lab_pkg::RegLin:     prdata = cfg_q.lin_coeff;
      lab_pkg::RegQuad:    prdata = cfg_q.quad_coeff;
      lab_pkg::RegMinDist: prdata = lab_pkg::DataW'(cfg_q.min_distance);
      default:             prdata = '0;
    endcase
  end

  // pipeline moves while the skid entry is free
  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  lab_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .cfg_i      (cfg_q),
    .valid_i    (in_valid_i),
    .distance_i (distance_i),
    .valid_o    (front_v),
    .front_o    (front)
  );

  lab_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .valid_i (front_v),
    .front_i (front),
    .valid_o (poly_v),
    .div_o   (div_in)
  );

  lab_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (poly_v),
    .div_i   (div_in),
    .valid_o (pipe_v),
    .res_o   (pipe_res)
  );

  // output register with one skid entry
  assign pipe_move = pipe_v && en;
  assign out_take  = out_v_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || out_take) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= pipe_move;
      end
    end else if (pipe_move) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_take) begin
      out_q <= skid_v_q ? skid_q : pipe_res;
    end else if (pipe_move) begin
      skid_q <= pipe_res;
    end
  end

  assign out_valid_o  = out_v_q;
  assign brightness_o = $signed(out_q.brightness);
  assign saturated_o  = out_q.saturated;

  // skid holds a result only behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry full with empty output register");

  // skid fills only when the output was stalled
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && out_stall_i))
    else $error("skid entry filled without an output stall");

  // a clipped result sits at one end of the range
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (out_q.brightness == lab_pkg::MaxS32 || out_q.brightness == lab_pkg::MinS32))
    else $error("saturated result not at a range limit");

endmodule
